@@ rtl/box_mean_filter_zero_pad_macros.svh @@
// Assertion macros for the box mean filter.
`ifndef BOX_MEAN_FILTER_ZERO_PAD_MACROS_SVH
`define BOX_MEAN_FILTER_ZERO_PAD_MACROS_SVH

// implication checked at every clock outside reset
`define BMF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition that must never hold outside reset
`define BMF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ rtl/bmf_pkg.sv @@
// Package with defaults and register indexes of the box mean filter.
`default_nettype none
package bmf_pkg;
  localparam int DEF_MAX_WINDOW = 7;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int CFG_WIDTH = 11;
  localparam int IDX_WIDTH = 2;

  localparam logic [IDX_WIDTH-1:0] REG_WINDOW_SIZE  = 2'd0;
  localparam logic [IDX_WIDTH-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [IDX_WIDTH-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [2:0]  RST_WINDOW_SIZE  = 3'd7;
  localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd512;
  localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd512;
endpackage
`default_nettype wire

@@ rtl/box_mean_filter_zero_pad.sv @@
// K x K box mean filter with zero padding over a line store memory.
// An item that yields no result leaves the filter idle; an item that yields a result
// passes through the accept cycle, one line store read per window tap, the tail state
// that collects the last tap, shift-subtract division of the eight quotient bits and
// the output state, which holds while the output stalls; in_stall is high until idle.
// Results lag their pixel by (K/2)*W + K/2 items; past the last pixel each item drains one.
// Reset clears counters, the frame flag and config (to defaults), not the line store.
`default_nettype none
module box_mean_filter_zero_pad #(
  parameter int MAX_WINDOW = bmf_pkg::DEF_MAX_WINDOW,
  parameter int MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmf_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [bmf_pkg::IDX_WIDTH-1:0]  cfg_index,
  input  wire logic [bmf_pkg::CFG_WIDTH-1:0]  cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           command,
  input  wire logic [7:0]                     pixel,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [7:0]                          mean_value,
  output logic                                last_of_frame
);
  localparam int KW   = $clog2(MAX_WINDOW + 1);
  localparam int KMAX = (MAX_WINDOW - 1) | 1;
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int SW   = ((WW > HW) ? WW : HW) + 2;
  localparam int AW   = $clog2((MAX_WINDOW - 1) * MAX_WIDTH + MAX_WINDOW);
  localparam int DEPTH = 1 << AW;
  localparam int PW   = $clog2((MAX_HEIGHT + MAX_WINDOW) * MAX_WIDTH + 1);
  localparam int SMW  = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
  localparam int DW   = SMW + 8;
  localparam int KKW  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_TAIL = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  window_size;
  logic [10:0] image_width;
  logic [10:0] image_height;

  logic [2:0]        state;
  logic              busy;
  logic [KW-1:0]     k_eff;
  logic [WW-1:0]     w_eff;
  logic [HW-1:0]     hgt_eff;
  logic [PW-1:0]     lag;
  logic [WW-1:0]     in_col;
  logic [HW-1:0]     in_row;
  logic [WW-1:0]     out_col;
  logic [HW-1:0]     out_row;
  logic [PW-1:0]     pcount;
  logic [AW-1:0]     ocount;
  logic [AW-1:0]     addr;
  logic [KW-1:0]     dx;
  logic [KW-1:0]     dy;
  logic signed [SW-1:0] rr;
  logic signed [SW-1:0] cc;
  logic signed [SW-1:0] cc0;
  logic              rd_ok;
  logic [7:0]        rd_data;
  logic [SMW-1:0]    rem;
  logic [DW-1:0]     dsh;
  logic [2:0]        step;
  logic [7:0]        quot;
  logic              last;

  logic [7:0] mem [DEPTH];

  logic [2:0]    k_odd;
  logic [KW-1:0] k_cfg;
  logic [WW-1:0] w_cfg;
  logic [HW-1:0] hgt_cfg;
  logic [KW-1:0] k_use;
  logic [KW-1:0] half_use;
  logic [WW-1:0] w_use;
  logic [HW-1:0] hgt_use;
  logic [PW-1:0] lag_cfg;
  logic [PW-1:0] lag_use;
  logic [KKW-1:0] kk_use;
  logic          accept;
  logic          draining;
  logic          do_pix;
  logic          emit;
  logic          at_last;
  logic          tap_in;

  always_comb begin
    k_odd   = window_size | 3'b001;
    k_cfg   = (32'(k_odd) > KMAX) ? KW'(KMAX) : KW'(k_odd);
    w_cfg   = (image_width == 11'd0) ? WW'(1) :
              (32'(image_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(image_width);
    hgt_cfg = (image_height == 11'd0) ? HW'(1) :
              (32'(image_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(image_height);
    lag_cfg = PW'(k_cfg >> 1) * PW'(w_cfg) + PW'(k_cfg >> 1);
    k_use    = busy ? k_eff : k_cfg;
    w_use    = busy ? w_eff : w_cfg;
    hgt_use  = busy ? hgt_eff : hgt_cfg;
    lag_use  = busy ? lag : lag_cfg;
    half_use = k_use >> 1;
    kk_use   = KKW'(KKW'(k_use) * KKW'(k_use));
    accept   = in_valid && (state == S_IDLE);
    draining = busy && (in_row >= hgt_eff);
    do_pix   = !command && !draining;
    emit     = draining || (do_pix && (pcount >= lag_use));
    at_last  = (out_row == hgt_use - HW'(1)) && (out_col == w_use - WW'(1));
    tap_in   = !rr[SW-1] && (rr < $signed(SW'(hgt_eff))) &&
               !cc[SW-1] && (cc < $signed(SW'(w_eff)));
  end

  assign in_stall      = (state != S_IDLE);
  assign out_valid     = (state == S_OUT);
  assign mean_value    = quot;
  assign last_of_frame = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= bmf_pkg::RST_WINDOW_SIZE;
      image_width  <= bmf_pkg::RST_IMAGE_WIDTH;
      image_height <= bmf_pkg::RST_IMAGE_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bmf_pkg::REG_WINDOW_SIZE:  window_size  <= cfg_data[2:0];
        bmf_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        bmf_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && do_pix) begin
      mem[pcount[AW-1:0]] <= pixel;
    end
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      busy    <= 1'b0;
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      pcount  <= '0;
      ocount  <= '0;
      rd_ok   <= 1'b0;
      k_eff   <= '0;
      w_eff   <= '0;
      hgt_eff <= '0;
      lag     <= '0;
    end else begin
      rd_ok <= (state == S_SCAN) && tap_in;
      if (rd_ok) begin
        rem <= rem + SMW'(rd_data);
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (do_pix) begin
              if (!busy) begin
                busy    <= 1'b1;
                k_eff   <= k_cfg;
                w_eff   <= w_cfg;
                hgt_eff <= hgt_cfg;
                lag     <= lag_cfg;
              end
              pcount <= pcount + PW'(1);
              if (in_col == w_use - WW'(1)) begin
                in_col <= '0;
                in_row <= in_row + HW'(1);
              end else begin
                in_col <= in_col + WW'(1);
              end
            end
            if (emit) begin
              rem   <= '0;
              dsh   <= DW'(kk_use) << 7;
              rr    <= SW'(out_row) - SW'(half_use);
              cc    <= SW'(out_col) - SW'(half_use);
              cc0   <= SW'(out_col) - SW'(half_use);
              addr  <= ocount - lag_use[AW-1:0];
              dx    <= '0;
              dy    <= '0;
              last  <= at_last;
              state <= S_SCAN;
              if (at_last) begin
                busy    <= 1'b0;
                in_col  <= '0;
                in_row  <= '0;
                out_col <= '0;
                out_row <= '0;
                pcount  <= '0;
                ocount  <= '0;
              end else begin
                ocount <= ocount + AW'(1);
                if (out_col == w_use - WW'(1)) begin
                  out_col <= '0;
                  out_row <= out_row + HW'(1);
                end else begin
                  out_col <= out_col + WW'(1);
                end
              end
            end
          end
        end
        S_SCAN: begin
          if (dx == k_eff - KW'(1)) begin
            dx   <= '0;
            dy   <= dy + KW'(1);
            rr   <= rr + SW'(1);
            cc   <= cc0;
            addr <= addr + AW'(w_eff) - AW'(k_eff) + AW'(1);
            if (dy == k_eff - KW'(1)) begin
              state <= S_TAIL;
            end
          end else begin
            dx   <= dx + KW'(1);
            cc   <= cc + SW'(1);
            addr <= addr + AW'(1);
          end
        end
        S_TAIL: begin
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (DW'(rem) >= dsh) begin
            rem  <= rem - SMW'(dsh);
            quot <= {quot[6:0], 1'b1};
          end else begin
            quot <= {quot[6:0], 1'b0};
          end
          dsh  <= dsh >> 1;
          step <= step + 3'd1;
          if (step == 3'd7) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "box_mean_filter_zero_pad_macros.svh"

  `BMF_ASSERT_IMPLY(a_rd_ok_scan, rd_ok, $past(state == S_SCAN), "tap read outside window scan")
  `BMF_ASSERT_IMPLY(a_div_bound, state == S_DIV, DW'(rem) < (dsh << 1), "quotient bit overflow")
  `BMF_ASSERT_NEVER(a_idle_counts, !busy && ((pcount != '0) || (out_row != '0) || (ocount != '0)), "counters set outside frame")

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the K x K zero-padded box mean filter.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  localparam int MAXK       = bmf_pkg::DEF_MAX_WINDOW;
  localparam int MAXW       = bmf_pkg::DEF_MAX_WIDTH;
  localparam int MAXH       = bmf_pkg::DEF_MAX_HEIGHT;
  localparam int IW         = bmf_pkg::IDX_WIDTH;
  localparam int CW         = bmf_pkg::CFG_WIDTH;
  localparam int HIST_DEPTH = (MAXK - 1) * MAXW + MAXK;
  localparam int SETTLE     = MAXK * MAXK + 40;
  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_PIXELS = 1200;

  typedef struct packed {
    logic [7:0] mean_value;
    logic       last_of_frame;
  } mean_beat_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [IW-1:0]        cfg_index;
  logic [CW-1:0]        cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 command;
  logic [7:0]           pixel;
  logic                 out_valid;
  logic                 out_stall;
  logic [7:0]           mean_value;
  logic                 last_of_frame;

  box_mean_filter_zero_pad u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .pixel(pixel),
    .out_valid(out_valid), .out_stall(out_stall),
    .mean_value(mean_value), .last_of_frame(last_of_frame)
  );

  // filter shadow state
  logic [7:0]  pix_hist [0:HIST_DEPTH-1];
  int unsigned in_col, in_row, out_col, out_row;
  int unsigned k_lat, w_lat, h_lat;
  bit          frame_busy;
  logic [2:0]  win_reg;
  logic [10:0] width_reg, height_reg;

  mean_beat_t  mean_q [$];
  int          err_count;
  int          pixels_sent;
  bit          idle_on;
  bit          stall_on;
  bit          long_hold_req;
  int          hold_left;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    err_count++;
  endtask

  task automatic latch_frame_config();
    int unsigned k;
    k = win_reg | 3'd1;
    if (k > ((MAXK - 1) | 1)) k = (MAXK - 1) | 1;
    k_lat = k;
    w_lat = (width_reg == 0) ? 1 : width_reg;
    if (w_lat > MAXW) w_lat = MAXW;
    h_lat = (height_reg == 0) ? 1 : height_reg;
    if (h_lat > MAXH) h_lat = MAXH;
  endtask

  task automatic emit_mean();
    int half, rr, cc;
    int unsigned sum;
    mean_beat_t b;
    half = k_lat / 2;
    sum = 0;
    for (int dy = 0; dy < k_lat; dy++) begin
      rr = int'(out_row) + dy - half;
      for (int dx = 0; dx < k_lat; dx++) begin
        cc = int'(out_col) + dx - half;
        if (rr >= 0 && rr < h_lat && cc >= 0 && cc < w_lat)
          sum += pix_hist[(rr * w_lat + cc) % HIST_DEPTH];
      end
    end
    b.mean_value = 8'(sum / (k_lat * k_lat));
    b.last_of_frame = (out_row == h_lat - 1) && (out_col == w_lat - 1);
    mean_q.push_back(b);
    if (b.last_of_frame) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      frame_busy = 0;
    end else begin
      out_col++;
      if (out_col >= w_lat) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  function automatic bit draining();
    return frame_busy && in_row >= h_lat;
  endfunction

  task automatic predict_mean(input bit cmd, input logic [7:0] pix);
    int unsigned half, p;
    if (cmd || draining()) begin
      if (draining()) emit_mean();
      return;
    end
    if (!frame_busy) begin
      latch_frame_config();
      frame_busy = 1;
    end
    half = k_lat / 2;
    p = in_row * w_lat + in_col;
    pix_hist[p % HIST_DEPTH] = pix;
    in_col++;
    if (in_col >= w_lat) begin
      in_col = 0;
      in_row++;
    end
    if (p >= half * w_lat + half) emit_mean();
  endtask

  task automatic send_item(input bit cmd, input logic [7:0] pix);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    command <= cmd;
    pixel <= pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_mean(cmd, pix);
    if (!cmd) pixels_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [CW-1:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      bmf_pkg::REG_WINDOW_SIZE:  win_reg = val[2:0];
      bmf_pkg::REG_IMAGE_WIDTH:  width_reg = val;
      bmf_pkg::REG_IMAGE_HEIGHT: height_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (mean_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_pixel();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  // drive one frame, then drain it with flush and dropped-pixel beats
  task automatic run_frame(input int k, input int w, input int h, input bit noisy);
    int n;
    write_reg(bmf_pkg::REG_WINDOW_SIZE, CW'(k));
    write_reg(bmf_pkg::REG_IMAGE_WIDTH, CW'(w));
    write_reg(bmf_pkg::REG_IMAGE_HEIGHT, CW'(h));
    latch_frame_config();
    n = w_lat * h_lat;
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 7) == 0) send_item(1'b1, 8'($urandom));
      send_item(1'b0, pick_pixel());
    end
    while (frame_busy) begin
      if (draining()) send_item(1'($urandom_range(0, 1)), 8'($urandom));
      else send_item(1'b0, pick_pixel());
    end
    settle();
  endtask

  task automatic test_flush_while_idle();
    send_item(1'b1, 8'hFF);
    send_item(1'b1, 8'h00);
    settle();
  endtask

  task automatic test_pixel_extremes();
    write_reg(bmf_pkg::REG_WINDOW_SIZE, CW'(3));
    write_reg(bmf_pkg::REG_IMAGE_WIDTH, CW'(4));
    write_reg(bmf_pkg::REG_IMAGE_HEIGHT, CW'(3));
    for (int i = 0; i < 12; i++) send_item(1'b0, (i % 2) ? 8'hFF : 8'h00);
    send_item(1'b1, 8'h00);
    while (frame_busy) send_item(1'b0, 8'hFF);
    settle();
    run_frame(1, 3, 2, 0);
  endtask

  task automatic test_even_windows();
    run_frame(0, 3, 3, 1);
    run_frame(2, 4, 3, 1);
    run_frame(4, 5, 5, 1);
    run_frame(6, 8, 7, 1);
  endtask

  task automatic test_degenerate_sizes();
    run_frame(3, 0, 0, 0);
    run_frame(7, 1, 1, 0);
    run_frame(5, 2, 1, 1);
  endtask

  task automatic test_large_sizes();
    run_frame(1, 2047, 1, 0);
  endtask

  task automatic test_back_pressure();
    write_reg(bmf_pkg::REG_WINDOW_SIZE, CW'(3));
    write_reg(bmf_pkg::REG_IMAGE_WIDTH, CW'(6));
    write_reg(bmf_pkg::REG_IMAGE_HEIGHT, CW'(6));
    for (int i = 0; i < 12; i++) send_item(1'b0, pick_pixel());
    long_hold_req = 1;
    for (int i = 0; i < 12; i++) send_item(1'b0, pick_pixel());
    @(negedge clk);
    in_valid <= 1'b0;
    wait (mean_q.size() == 0);
    for (int i = 0; i < 12; i++) send_item(1'b0, pick_pixel());
    while (frame_busy) send_item(1'b1, 8'h00);
    settle();
  endtask

  task automatic test_random_frames();
    int w, h;
    while (pixels_sent < RANDOM_PIXELS) begin
      if (pixels_sent > RANDOM_PIXELS * 4 / 5) begin
        idle_on = 0;
        stall_on = 0;
      end
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      h = $urandom_range(1, 10);
      run_frame($urandom_range(0, 7), w, h, 1);
    end
  endtask

  // receiver stall bursts, plus one long hold on request
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 0;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      hold_left <= $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    mean_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (mean_q.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = mean_q.pop_front();
        if (mean_value !== want.mean_value)
          report_mismatch($sformatf("mean_value %0d, want %0d", mean_value, want.mean_value));
        if (last_of_frame !== want.last_of_frame)
          report_mismatch($sformatf("last_of_frame %0b, want %0b",
                                    last_of_frame, want.last_of_frame));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("TIMEOUT after %0d quiet cycles", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    command = 1'b0;
    pixel = '0;
    out_stall = 1'b0;
    hold_left = 0;
    long_hold_req = 0;
    quiet_cycles = 0;
    err_count = 0;
    pixels_sent = 0;
    idle_on = 1;
    stall_on = 1;
    for (int i = 0; i < HIST_DEPTH; i++) pix_hist[i] = '0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    frame_busy = 0;
    win_reg = bmf_pkg::RST_WINDOW_SIZE;
    width_reg = bmf_pkg::RST_IMAGE_WIDTH;
    height_reg = bmf_pkg::RST_IMAGE_HEIGHT;
    latch_frame_config();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_flush_while_idle();
    test_pixel_extremes();
    test_even_windows();
    test_degenerate_sizes();
    test_back_pressure();
    test_large_sizes();
    test_random_frames();

    settle();
    if (mean_q.size() != 0) report_mismatch("expected results left over");
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
